// ===== src/ngram_skipgram_histogram_assert.svh =====
// Assertion macros for the n-gram histogram block.
// Depends on clk_i and rst_ni in the scope that uses them.
`ifndef NGRAM_SKIPGRAM_HISTOGRAM_ASSERT_SVH
`define NGRAM_SKIPGRAM_HISTOGRAM_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NGSH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NGSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ngsh_pkg.sv =====
// Shared constants, codes and types of the n-gram histogram block.
// No dependencies.
`default_nettype none

package ngsh_pkg;

  // Default sizing
  localparam int ALPHABET_DEF    = 32;
  localparam int HISTORY_LEN_DEF = 11;

  // Field widths
  localparam int SYM_W  = 6;
  localparam int SEL_W  = 4;
  localparam int IDX_W  = 5;
  localparam int CODE_W = 5;
  localparam int CNT_W  = 32;

  // Command codes
  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Table select codes
  localparam logic [SEL_W-1:0] SEL_MONO  = 4'd0;
  localparam logic [SEL_W-1:0] SEL_BI    = 4'd1;
  localparam logic [SEL_W-1:0] SEL_TRI   = 4'd2;
  localparam logic [SEL_W-1:0] SEL_QUAD  = 4'd3;
  localparam logic [SEL_W-1:0] SEL_SKIP1 = 4'd4;

  // One history entry
  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } hist_t;

endpackage

`default_nettype wire

// ===== src/ngram_skipgram_histogram.sv =====
// N-gram and skip-gram histogram: top level, count memories and sequencer.
// Depends on ngsh_pkg and ngram_skipgram_histogram_assert.svh.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low.
//   command_i = count: symbol_i is counted; no result. A valid symbol keeps
//   busy high while one increment of the shared small-table memory is done
//   per cycle (mono, bi, tri, then one per skip distance), pipelined read
//   then write, plus a drain state to finish the last write. The quadgram
//   increment runs in its own memory alongside the monogram step. An
//   invalid symbol only shifts the history and leaves busy low.
//   command_i = read: count_valid_o pulses in the cycle after the request,
//   with count_value_o; busy stays low, so reads go one per cycle while idle.
//   The receiver cannot stall; each result is shown for one cycle only.
//   After reset the block clears both memories, one address per cycle;
//   busy is high meanwhile. The history starts with all entries invalid.
`default_nettype none
`include "ngram_skipgram_histogram_assert.svh"

module ngram_skipgram_histogram
  import ngsh_pkg::*;
#(
  parameter int ALPHABET    = ALPHABET_DEF,
  parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output      logic                     busy,
  input  wire logic                     command_i,
  input  wire logic signed [SYM_W-1:0]  symbol_i,
  input  wire logic        [SEL_W-1:0]  table_select_i,
  input  wire logic        [IDX_W-1:0]  index_a_i,
  input  wire logic        [IDX_W-1:0]  index_b_i,
  input  wire logic        [IDX_W-1:0]  index_c_i,
  input  wire logic        [IDX_W-1:0]  index_d_i,
  output      logic                     count_valid_o,
  output      logic        [CNT_W-1:0]  count_value_o
);

  localparam int NSKIP       = HISTORY_LEN - 2;
  localparam int NSTEP       = NSKIP + 3;
  localparam int A2          = ALPHABET * ALPHABET;
  localparam int A3          = A2 * ALPHABET;
  localparam int A4          = A3 * ALPHABET;
  localparam int MONO_BASE   = 0;
  localparam int BI_BASE     = ALPHABET;
  localparam int TRI_BASE    = BI_BASE + A2;
  localparam int SKIP_BASE   = TRI_BASE + A3;
  localparam int SMALL_DEPTH = SKIP_BASE + NSKIP * A2;
  localparam int QUAD_DEPTH  = A4;
  localparam int CLR_LEN     = (SMALL_DEPTH > QUAD_DEPTH) ? SMALL_DEPTH : QUAD_DEPTH;
  localparam int SAW         = $clog2(SMALL_DEPTH);
  localparam int QAW         = $clog2(QUAD_DEPTH);
  localparam int CAW         = $clog2(CLR_LEN);
  localparam int SW          = $clog2(NSTEP);
  localparam int HW          = $clog2(HISTORY_LEN);

  // Sequencer state codes
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_COUNT = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  // Count step codes; steps past the trigram are skip distances
  localparam logic [SW-1:0] STEP_MONO = SW'(0);
  localparam logic [SW-1:0] STEP_BI   = SW'(1);
  localparam logic [SW-1:0] STEP_TRI  = SW'(2);
  localparam logic [SW-1:0] STEP_LAST = SW'(NSTEP - 1);

  logic [1:0]       state_q, state_d;
  logic [CAW-1:0]   clr_q;
  logic [SW-1:0]    step_q;
  hist_t            hist_q [HISTORY_LEN];

  logic [CNT_W-1:0] small_mem [SMALL_DEPTH];
  logic [CNT_W-1:0] quad_mem  [QUAD_DEPTH];
  logic [CNT_W-1:0] s_rdata_q, q_rdata_q;

  logic             s_wpend_q, q_wpend_q;
  logic [SAW-1:0]   s_wadr_q;
  logic [QAW-1:0]   q_wadr_q;
  logic             rd_out_q, rd_ok_q, rd_quad_q;

  logic             accept, acc_count, acc_read, sym_ok;
  logic             clr_active;

  // Read request decode
  logic             rd_ok, rd_quad;
  logic [SAW-1:0]   rd_saddr;
  logic [QAW-1:0]   rd_qaddr;

  // Count step decode
  logic             st_en, quad_en;
  logic [SAW-1:0]   st_addr;
  logic [QAW-1:0]   quad_addr;
  logic [HW-1:0]    hidx;

  // Memory ports
  logic             s_re, s_we, q_re, q_we;
  logic [SAW-1:0]   s_raddr, s_waddr;
  logic [QAW-1:0]   q_raddr, q_waddr;
  logic [CNT_W-1:0] s_wdata, q_wdata;

  assign busy       = (state_q != ST_IDLE);
  assign accept     = start && !busy;
  assign acc_count  = accept && (command_i == CMD_COUNT);
  assign acc_read   = accept && (command_i == CMD_READ);
  assign clr_active = (state_q == ST_CLEAR);

  // Symbol is counted only from 1 to ALPHABET-1
  assign sym_ok = !symbol_i[SYM_W-1] && (symbol_i[CODE_W-1:0] != '0) &&
                  (int'(symbol_i[CODE_W-1:0]) < ALPHABET);

  // Decode a read request into a table address
  always_comb begin
    logic a_ok, b_ok, c_ok, d_ok;
    a_ok     = int'(index_a_i) < ALPHABET;
    b_ok     = int'(index_b_i) < ALPHABET;
    c_ok     = int'(index_c_i) < ALPHABET;
    d_ok     = int'(index_d_i) < ALPHABET;
    rd_ok    = 1'b0;
    rd_quad  = 1'b0;
    rd_saddr = '0;
    rd_qaddr = QAW'(index_a_i) * QAW'(A3) + QAW'(index_b_i) * QAW'(A2) +
               QAW'(index_c_i) * QAW'(ALPHABET) + QAW'(index_d_i);
    unique case (table_select_i)
      SEL_MONO: begin
        rd_ok    = a_ok;
        rd_saddr = SAW'(MONO_BASE) + SAW'(index_a_i);
      end
      SEL_BI: begin
        rd_ok    = a_ok && b_ok;
        rd_saddr = SAW'(BI_BASE) + SAW'(index_a_i) * SAW'(ALPHABET) + SAW'(index_b_i);
      end
      SEL_TRI: begin
        rd_ok    = a_ok && b_ok && c_ok;
        rd_saddr = SAW'(TRI_BASE) + SAW'(index_a_i) * SAW'(A2) +
                   SAW'(index_b_i) * SAW'(ALPHABET) + SAW'(index_c_i);
      end
      SEL_QUAD: begin
        rd_ok   = a_ok && b_ok && c_ok && d_ok;
        rd_quad = 1'b1;
      end
      default: begin
        rd_ok    = a_ok && b_ok && (int'(table_select_i) - int'(SEL_SKIP1) < NSKIP);
        rd_saddr = SAW'(SKIP_BASE) +
                   SAW'((int'(table_select_i) - int'(SEL_SKIP1)) * A2) +
                   SAW'(index_a_i) * SAW'(ALPHABET) + SAW'(index_b_i);
      end
    endcase
  end

  // Decode the current count step; history is already shifted, so the
  // counted symbol sits in entry 0 and the earlier ones one place further
  always_comb begin
    logic [CODE_W-1:0] v, p1, p2, p3;
    v         = hist_q[0].code;
    p1        = hist_q[1].code;
    p2        = hist_q[2].code;
    p3        = hist_q[3].code;
    hidx      = '0;
    quad_en   = hist_q[1].valid && hist_q[2].valid && hist_q[3].valid;
    quad_addr = QAW'(p3) * QAW'(A3) + QAW'(p2) * QAW'(A2) +
                QAW'(p1) * QAW'(ALPHABET) + QAW'(v);
    unique case (step_q)
      STEP_MONO: begin
        st_en   = 1'b1;
        st_addr = SAW'(MONO_BASE) + SAW'(v);
      end
      STEP_BI: begin
        st_en   = hist_q[1].valid;
        st_addr = SAW'(BI_BASE) + SAW'(p1) * SAW'(ALPHABET) + SAW'(v);
      end
      STEP_TRI: begin
        st_en   = hist_q[1].valid && hist_q[2].valid;
        st_addr = SAW'(TRI_BASE) + SAW'(p2) * SAW'(A2) + SAW'(p1) * SAW'(ALPHABET) +
                  SAW'(v);
      end
      default: begin
        hidx    = HW'(int'(step_q) - 1);
        st_en   = hist_q[hidx].valid;
        st_addr = SAW'(SKIP_BASE) + SAW'((int'(step_q) - 3) * A2) +
                  SAW'(hist_q[hidx].code) * SAW'(ALPHABET) + SAW'(v);
      end
    endcase
  end

  // Steer memory ports
  always_comb begin
    s_re    = 1'b0;
    s_raddr = rd_saddr;
    q_re    = 1'b0;
    q_raddr = rd_qaddr;
    if (state_q == ST_IDLE) begin
      s_re = acc_read && rd_ok && !rd_quad;
      q_re = acc_read && rd_ok && rd_quad;
    end else if (state_q == ST_COUNT) begin
      s_re    = st_en;
      s_raddr = st_addr;
      q_re    = (step_q == STEP_MONO) && quad_en;
      q_raddr = quad_addr;
    end
    s_we    = (clr_active && (int'(clr_q) < SMALL_DEPTH)) || s_wpend_q;
    s_waddr = clr_active ? clr_q[SAW-1:0] : s_wadr_q;
    s_wdata = clr_active ? '0 : ((&s_rdata_q) ? s_rdata_q : s_rdata_q + CNT_W'(1));
    q_we    = (clr_active && (int'(clr_q) < QUAD_DEPTH)) || q_wpend_q;
    q_waddr = clr_active ? clr_q[QAW-1:0] : q_wadr_q;
    q_wdata = clr_active ? '0 : ((&q_rdata_q) ? q_rdata_q : q_rdata_q + CNT_W'(1));
  end

  // Count memories
  always_ff @(posedge clk_i) begin
    if (s_we) begin
      small_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rdata_q <= small_mem[s_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      quad_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rdata_q <= quad_mem[q_raddr];
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == CAW'(CLR_LEN - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (acc_count && sym_ok) state_d = ST_COUNT;
      ST_COUNT: if (step_q == STEP_LAST) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      step_q    <= '0;
      s_wpend_q <= 1'b0;
      q_wpend_q <= 1'b0;
      rd_out_q  <= 1'b0;
      for (int i = 0; i < HISTORY_LEN; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      rd_out_q <= acc_read;
      // Advance the clearing sweep
      if (clr_active) begin
        clr_q <= clr_q + CAW'(1);
      end
      // Advance the count steps
      if (state_q == ST_COUNT) begin
        step_q <= step_q + SW'(1);
      end else begin
        step_q <= '0;
      end
      // Hold a pending write-back for the step just read
      s_wpend_q <= (state_q == ST_COUNT) && st_en;
      q_wpend_q <= (state_q == ST_COUNT) && (step_q == STEP_MONO) && quad_en;
      // Shift the history on every count request
      if (acc_count) begin
        for (int i = HISTORY_LEN - 1; i > 0; i--) begin
          hist_q[i] <= hist_q[i - 1];
        end
        hist_q[0].valid <= sym_ok;
        hist_q[0].code  <= sym_ok ? symbol_i[CODE_W-1:0] : '0;
      end
    end
  end

  // Write-back addresses and read result qualifiers
  always_ff @(posedge clk_i) begin
    s_wadr_q <= st_addr;
    q_wadr_q <= quad_addr;
    if (acc_read) begin
      rd_ok_q   <= rd_ok;
      rd_quad_q <= rd_quad;
    end
  end

  assign count_valid_o = rd_out_q;
  assign count_value_o = !rd_ok_q ? '0 : (rd_quad_q ? q_rdata_q : s_rdata_q);

  // Checks
  `NGSH_ASSERT_NEXT(a_read_result, acc_read, count_valid_o, "read request gave no result")
  `NGSH_ASSERT_NOW(a_result_idle, count_valid_o, state_q == ST_IDLE, "result while busy")
  `NGSH_ASSERT_NOW(a_write_busy, s_we || q_we, busy, "count memory written while idle")
  `NGSH_ASSERT_NEXT(a_bad_sym, acc_count && !sym_ok, !busy && !s_wpend_q,
                    "invalid symbol started counting")

endmodule

`default_nettype wire

// ===== tb/ngram_histogram_checker.sv =====
// Checker for the n-gram histogram block: watches requests and count results,
// keeps its own count tables and history, and compares every returned count.
// Depends on ngsh_pkg.
`timescale 1ns / 1ps

module ngram_histogram_checker
  import ngsh_pkg::*;
#(
  parameter int ALPHABET    = ALPHABET_DEF,
  parameter int HISTORY_LEN = HISTORY_LEN_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  input  logic                    busy,
  input  logic                    command_i,
  input  logic signed [SYM_W-1:0] symbol_i,
  input  logic        [SEL_W-1:0] table_select_i,
  input  logic        [IDX_W-1:0] index_a_i,
  input  logic        [IDX_W-1:0] index_b_i,
  input  logic        [IDX_W-1:0] index_c_i,
  input  logic        [IDX_W-1:0] index_d_i,
  input  logic                    count_valid_o,
  input  logic        [CNT_W-1:0] count_value_o,
  output int                      errors_o,
  output int                      pending_o
);

  localparam int DEPTH = HISTORY_LEN - 1;
  localparam int SKIPS = HISTORY_LEN - 2;
  localparam int KEY_W = SEL_W + 4 * IDX_W;

  // Sparse count tables: key is {table select, entry indexes}, absent means zero
  logic [CNT_W-1:0]  tally[logic [KEY_W-1:0]];
  logic [CNT_W-1:0]  expected_counts[$];
  bit                recent_ok[DEPTH];
  logic [CODE_W-1:0] recent_sym[DEPTH];
  int                mismatches;

  task automatic report(input string what, input logic [CNT_W-1:0] got,
                        input logic [CNT_W-1:0] want);
    $display("ERROR at %0t: %s: got %h, want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Increment one entry, holding at the top value
  function automatic void bump(input logic [KEY_W-1:0] key);
    if (!tally.exists(key)) begin
      tally[key] = 1;
    end else if (tally[key] != '1) begin
      tally[key] = tally[key] + 1;
    end
  endfunction

  // Count one symbol along the n-gram chain and the skip distances, then shift
  function automatic void count_symbol(input logic signed [SYM_W-1:0] sym);
    bit                ok;
    logic [CODE_W-1:0] v;
    ok = (sym > 0) && (sym < ALPHABET);
    v  = sym[CODE_W-1:0];
    if (ok) begin
      bump({SEL_MONO, 15'b0, v});
      if (recent_ok[0]) begin
        bump({SEL_BI, 10'b0, recent_sym[0], v});
        if (recent_ok[1]) begin
          bump({SEL_TRI, 5'b0, recent_sym[1], recent_sym[0], v});
          if (recent_ok[2]) begin
            bump({SEL_QUAD, recent_sym[2], recent_sym[1], recent_sym[0], v});
          end
        end
      end
      for (int k = 1; k <= SKIPS; k++) begin
        if (recent_ok[k]) begin
          bump({SEL_SKIP1 + SEL_W'(k - 1), 10'b0, recent_sym[k], v});
        end
      end
    end
    for (int k = DEPTH - 1; k > 0; k--) begin
      recent_ok[k]  = recent_ok[k-1];
      recent_sym[k] = recent_sym[k-1];
    end
    recent_ok[0]  = ok;
    recent_sym[0] = ok ? v : '0;
  endfunction

  // Look up the count that a read request should return
  function automatic logic [CNT_W-1:0] stored_count(input logic [SEL_W-1:0] sel,
      input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
      input logic [IDX_W-1:0] c, input logic [IDX_W-1:0] d);
    logic [KEY_W-1:0] key;
    bit               in_range;
    if (sel == SEL_MONO) begin
      in_range = a < ALPHABET;
      key      = {sel, 15'b0, a};
    end else if (sel == SEL_BI || (sel >= SEL_SKIP1 && sel < SEL_SKIP1 + SKIPS)) begin
      in_range = a < ALPHABET && b < ALPHABET;
      key      = {sel, 10'b0, a, b};
    end else if (sel == SEL_TRI) begin
      in_range = a < ALPHABET && b < ALPHABET && c < ALPHABET;
      key      = {sel, 5'b0, a, b, c};
    end else if (sel == SEL_QUAD) begin
      in_range = a < ALPHABET && b < ALPHABET && c < ALPHABET && d < ALPHABET;
      key      = {sel, a, b, c, d};
    end else begin
      return '0;
    end
    if (!in_range || !tally.exists(key)) return '0;
    return tally[key];
  endfunction

  // Check results first, then take the request of this edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally.delete();
      expected_counts.delete();
      for (int k = 0; k < DEPTH; k++) begin
        recent_ok[k]  = 1'b0;
        recent_sym[k] = '0;
      end
      mismatches = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (count_valid_o === 1'b1) begin
        if (expected_counts.size() == 0) begin
          report("count with no read request waiting", count_value_o, '0);
        end else begin
          logic [CNT_W-1:0] want;
          want = expected_counts.pop_front();
          if (count_value_o !== want) report("count_value mismatch", count_value_o, want);
        end
      end
      if (start && !busy) begin
        if (command_i == CMD_READ) begin
          expected_counts.push_back(stored_count(table_select_i, index_a_i, index_b_i,
                                                 index_c_i, index_d_i));
        end else begin
          count_symbol(symbol_i);
        end
      end
      errors_o  <= mismatches;
      pending_o <= expected_counts.size();
    end
  end

endmodule

// ===== tb/tb_ngram_skipgram_histogram.sv =====
// Testbench top for the n-gram histogram block: clock, reset, request stimulus
// and the verdict. Depends on ngsh_pkg, the block and ngram_histogram_checker.
`timescale 1ns / 1ps

module tb_ngram_skipgram_histogram;
  import ngsh_pkg::*;

  localparam int ITEMS       = 2000;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int TAIL        = HISTORY_LEN_DEF + 8;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    command_i;
  logic signed [SYM_W-1:0] symbol_i;
  logic        [SEL_W-1:0] table_select_i;
  logic        [IDX_W-1:0] index_a_i;
  logic        [IDX_W-1:0] index_b_i;
  logic        [IDX_W-1:0] index_c_i;
  logic        [IDX_W-1:0] index_d_i;
  logic                    count_valid_o;
  logic        [CNT_W-1:0] count_value_o;
  int                      fail_count;
  int                      open_reads;
  int                      cycle_count = 0;

  ngram_skipgram_histogram dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .symbol_i, .table_select_i,
    .index_a_i, .index_b_i, .index_c_i, .index_d_i, .count_valid_o, .count_value_o
  );

  ngram_histogram_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .command_i, .symbol_i, .table_select_i,
    .index_a_i, .index_b_i, .index_c_i, .index_d_i, .count_valid_o, .count_value_o,
    .errors_o(fail_count), .pending_o(open_reads)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stop a hung run; the limit covers the clearing pass after reset
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Present one request and hold it until it is taken with busy low
  task automatic issue(input logic cmd, input logic signed [SYM_W-1:0] sym,
                       input logic [SEL_W-1:0] sel, input logic [IDX_W-1:0] a,
                       input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] c,
                       input logic [IDX_W-1:0] d);
    start          <= 1'b1;
    command_i      <= cmd;
    symbol_i       <= sym;
    table_select_i <= sel;
    index_a_i      <= a;
    index_b_i      <= b;
    index_c_i      <= c;
    index_d_i      <= d;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic send_count(input logic signed [SYM_W-1:0] sym);
    issue(CMD_COUNT, sym, SEL_W'($urandom_range(0, 15)), IDX_W'($urandom),
          IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic send_read(input logic [SEL_W-1:0] sel, input logic [IDX_W-1:0] a,
                           input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] c,
                           input logic [IDX_W-1:0] d);
    issue(CMD_READ, SYM_W'($urandom), sel, a, b, c, d);
  endtask

  // Drop start for a number of cycles
  task automatic rest(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Mostly a small set of symbols so that n-grams repeat, some breaks
  function automatic logic signed [SYM_W-1:0] pick_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return SYM_W'($urandom_range(1, 4));
    if (r < 85) return SYM_W'($urandom_range(1, 31));
    if (r < 92) return 0;
    return SYM_W'($urandom_range(0, 63));
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if ($urandom_range(0, 99) < 80) return IDX_W'($urandom_range(1, 4));
    return IDX_W'($urandom_range(0, 31));
  endfunction

  function automatic int pick_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    bit calm;
    calm           = 1'b0;
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    command_i      <= CMD_COUNT;
    symbol_i       <= '0;
    table_select_i <= SEL_MONO;
    index_a_i      <= '0;
    index_b_i      <= '0;
    index_c_i      <= '0;
    index_d_i      <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reads of empty tables, including an unused select
    send_read(SEL_MONO, 0, 0, 0, 0);
    send_read(SEL_QUAD, 31, 31, 31, 31);
    send_read(4'd15, 31, 31, 31, 31);

    // Top code, invalid codes, then a long valid chain
    send_count(31);
    send_count(-1);
    send_count(0);
    send_count(-32);
    for (int s = 1; s <= 10; s++) send_count(SYM_W'(s));
    send_count(31);

    // Read back each table kind, shortest and longest skip
    send_read(SEL_MONO, 31, 0, 0, 0);
    send_read(SEL_BI, 1, 2, 31, 31);
    send_read(SEL_TRI, 1, 2, 3, 0);
    send_read(SEL_QUAD, 1, 2, 3, 4);
    send_read(SEL_SKIP1, 1, 3, 0, 0);
    send_read(SEL_SKIP1 + 4'd8, 1, 31, 0, 0);
    send_read(4'd13, 1, 31, 0, 0);
    send_read(SEL_BI, 10, 31, 0, 0);

    // Random mix of counts and reads with bursts and gaps
    for (int n = 0; n < ITEMS; n++) begin
      if (n % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 55) begin
        send_count(pick_symbol());
      end else begin
        send_read($urandom_range(0, 99) < 90 ? SEL_W'($urandom_range(0, 12))
                                             : SEL_W'($urandom_range(13, 15)),
                  pick_index(), pick_index(), pick_index(), pick_index());
      end
      if (n == ITEMS / 2) begin
        // Hold off until every read has returned
        start <= 1'b0;
        do @(posedge clk_i); while (open_reads != 0);
      end else begin
        rest(pick_gap(calm));
      end
    end

    // Drain outstanding reads, then let any count finish
    start <= 1'b0;
    do @(posedge clk_i); while (open_reads != 0);
    repeat (TAIL) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/ngsh_pkg.sv
src/ngram_skipgram_histogram.sv
tb/ngram_histogram_checker.sv
tb/tb_ngram_skipgram_histogram.sv
